@@ src/rgbyuv_pkg.sv @@
// Shared constants and types for the RGB to YUV 4:2:0 converter.
package rgbyuv_pkg;

   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 1;
   localparam int PIXEL_W     = 8;
   localparam int SUM_W       = 18;
   localparam int QUOT_W      = 11;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [CSR_DATA_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [CSR_DATA_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   typedef logic [PIXEL_W-1:0]        pixel_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [QUOT_W-1:0]  quot_type;

   // BT.601 studio-range weights
   localparam int Y_R  = 66;
   localparam int Y_G  = 129;
   localparam int Y_B  = 25;
   localparam int CB_R = -38;
   localparam int CB_G = -74;
   localparam int CB_B = 112;
   localparam int CR_R = 112;
   localparam int CR_G = -94;
   localparam int CR_B = -18;

   localparam int ROUND_BIAS = 128;
   localparam int FRAC_BITS  = 8;
   localparam int Y_OFFSET   = 16;
   localparam int C_OFFSET   = 128;
   localparam int PIXEL_MAX  = 255;

   typedef struct packed {
      pixel_type red;
      pixel_type green;
      pixel_type blue;
      logic      cb_valid;
      logic      cr_valid;
      logic      frame_end;
   } stage_type;

   typedef struct packed {
      pixel_type luma;
      logic      cb_valid;
      pixel_type cb_value;
      logic      cr_valid;
      pixel_type cr_value;
      logic      frame_end;
   } result_type;

endpackage

@@ src/rgb_to_yuv420_converter.sv @@
// RGB to YUV 4:2:0 converter: raster position tracking and BT.601 color conversion.
//
// One RGB pixel per item in raster order; one result per item, one item per clock
// while no result stall holds req_ready low. Each pixel passes an input register
// and then a result register before its result is presented. While a result waits,
// one more item is taken into the input register; after that req_ready follows
// rsp_ready. Luma comes with every pixel; Cb is flagged on even rows at even columns
// and Cr on even rows at odd columns, both values always computed.
// frame_width and frame_height are clamped to 2..MAX_DIM; frame_end marks the last
// pixel of the frame. Changing a dimension mid-frame does not reset the position.
module rgb_to_yuv420_converter #(
   parameter int MAX_DIM = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [rgbyuv_pkg::PIXEL_W-1:0]       req_red,
   input  logic [rgbyuv_pkg::PIXEL_W-1:0]       req_green,
   input  logic [rgbyuv_pkg::PIXEL_W-1:0]       req_blue,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [rgbyuv_pkg::PIXEL_W-1:0]       rsp_luma,
   output logic                                 rsp_cb_valid,
   output logic [rgbyuv_pkg::PIXEL_W-1:0]       rsp_cb_value,
   output logic                                 rsp_cr_valid,
   output logic [rgbyuv_pkg::PIXEL_W-1:0]       rsp_cr_value,
   output logic                                 rsp_frame_end,
   input  logic                                 csr_write_enable,
   input  logic [rgbyuv_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rgbyuv_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int CNT_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
   localparam int LIM_W = ((CNT_W > rgbyuv_pkg::CSR_DATA_W) ? CNT_W
                                                            : rgbyuv_pkg::CSR_DATA_W) + 2;
   localparam logic [LIM_W-1:0] DIM_MIN = LIM_W'(2);
   localparam logic [LIM_W-1:0] DIM_MAX = LIM_W'(MAX_DIM);

   logic [rgbyuv_pkg::CSR_DATA_W-1:0] frame_width_ff, frame_height_ff;
   logic [CNT_W-1:0]                  column_ff, column_in;
   logic [CNT_W-1:0]                  row_ff, row_in;
   logic                              stage_valid_ff, stage_valid_in;
   rgbyuv_pkg::stage_type             stage_ff, stage_in;
   logic                              result_valid_ff, result_valid_in;
   rgbyuv_pkg::result_type            result_ff, result_in;

   logic             req_accept, stage_advance, result_free;
   logic [LIM_W-1:0] last_col, last_row;
   logic             line_end, frame_last_row;

   function automatic logic [LIM_W-1:0] last_index(
      input logic [rgbyuv_pkg::CSR_DATA_W-1:0] dim
   );
      logic [LIM_W-1:0] d;
      d = LIM_W'(dim);
      if (d < DIM_MIN) begin
         d = DIM_MIN;
      end else if (d > DIM_MAX) begin
         d = DIM_MAX;
      end
      return d - LIM_W'(1);
   endfunction

   function automatic rgbyuv_pkg::sum_type weigh(
      input int                    coef,
      input rgbyuv_pkg::pixel_type px
   );
      rgbyuv_pkg::sum_type p;
      rgbyuv_pkg::sum_type c;
      p = rgbyuv_pkg::sum_type'({{(rgbyuv_pkg::SUM_W-rgbyuv_pkg::PIXEL_W){1'b0}}, px});
      c = rgbyuv_pkg::sum_type'(coef);
      return c * p;
   endfunction

   // floor((s + bias) / 256) + offset, saturated to 0..255
   function automatic rgbyuv_pkg::pixel_type finish(
      input rgbyuv_pkg::sum_type s,
      input int                  offset
   );
      rgbyuv_pkg::sum_type  t;
      rgbyuv_pkg::quot_type q;
      t = s + rgbyuv_pkg::sum_type'(rgbyuv_pkg::ROUND_BIAS);
      q = rgbyuv_pkg::quot_type'(t >>> rgbyuv_pkg::FRAC_BITS)
          + rgbyuv_pkg::quot_type'(offset);
      if (q < 0) begin
         return '0;
      end else if (q > rgbyuv_pkg::quot_type'(rgbyuv_pkg::PIXEL_MAX)) begin
         return rgbyuv_pkg::pixel_type'(rgbyuv_pkg::PIXEL_MAX);
      end
      return q[rgbyuv_pkg::PIXEL_W-1:0];
   endfunction

   assign result_free   = !result_valid_ff || rsp_ready;
   assign stage_advance = stage_valid_ff && result_free;
   assign req_ready     = !stage_valid_ff || result_free;
   assign req_accept    = req_valid && req_ready;

   assign last_col       = last_index(frame_width_ff);
   assign last_row       = last_index(frame_height_ff);
   assign line_end       = LIM_W'(column_ff) >= last_col;
   assign frame_last_row = LIM_W'(row_ff) >= last_row;

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (req_accept) begin
         if (line_end) begin
            column_in = '0;
            row_in    = frame_last_row ? '0 : row_ff + CNT_W'(1);
         end else begin
            column_in = column_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      stage_valid_in     = req_accept || (stage_valid_ff && !result_free);
      stage_in           = stage_ff;
      if (req_accept) begin
         stage_in.red       = req_red;
         stage_in.green     = req_green;
         stage_in.blue      = req_blue;
         stage_in.cb_valid  = !row_ff[0] && !column_ff[0];
         stage_in.cr_valid  = !row_ff[0] && column_ff[0];
         stage_in.frame_end = line_end && frame_last_row;
      end
   end

   always_comb begin
      rgbyuv_pkg::sum_type y_sum, cb_sum, cr_sum;
      y_sum  = weigh(rgbyuv_pkg::Y_R, stage_ff.red) + weigh(rgbyuv_pkg::Y_G, stage_ff.green)
               + weigh(rgbyuv_pkg::Y_B, stage_ff.blue);
      cb_sum = weigh(rgbyuv_pkg::CB_R, stage_ff.red) + weigh(rgbyuv_pkg::CB_G, stage_ff.green)
               + weigh(rgbyuv_pkg::CB_B, stage_ff.blue);
      cr_sum = weigh(rgbyuv_pkg::CR_R, stage_ff.red) + weigh(rgbyuv_pkg::CR_G, stage_ff.green)
               + weigh(rgbyuv_pkg::CR_B, stage_ff.blue);
      result_valid_in = stage_advance || (result_valid_ff && !rsp_ready);
      result_in       = result_ff;
      if (stage_advance) begin
         result_in.luma      = finish(y_sum, rgbyuv_pkg::Y_OFFSET);
         result_in.cb_valid  = stage_ff.cb_valid;
         result_in.cb_value  = finish(cb_sum, rgbyuv_pkg::C_OFFSET);
         result_in.cr_valid  = stage_ff.cr_valid;
         result_in.cr_value  = finish(cr_sum, rgbyuv_pkg::C_OFFSET);
         result_in.frame_end = stage_ff.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= rgbyuv_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= rgbyuv_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (rgbyuv_pkg::csr_index_type'(csr_index))
            rgbyuv_pkg::CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_write_data;
            end
            rgbyuv_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff       <= '0;
         row_ff          <= '0;
         stage_valid_ff  <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         column_ff       <= column_in;
         row_ff          <= row_in;
         stage_valid_ff  <= stage_valid_in;
         result_valid_ff <= result_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff  <= stage_in;
      result_ff <= result_in;
   end

   assign rsp_valid     = result_valid_ff;
   assign rsp_luma      = result_ff.luma;
   assign rsp_cb_valid  = result_ff.cb_valid;
   assign rsp_cb_value  = result_ff.cb_value;
   assign rsp_cr_valid  = result_ff.cr_valid;
   assign rsp_cr_value  = result_ff.cr_value;
   assign rsp_frame_end = result_ff.frame_end;

endmodule

@@ verif/yuv420_result_checker.sv @@
// Checker that predicts and compares every converted pixel of the RGB to YUV 4:2:0 block.
`timescale 1ns / 100ps

module yuv420_result_checker #(
   parameter int MAX_DIM = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  rgbyuv_pkg::pixel_type              req_red,
   input  rgbyuv_pkg::pixel_type              req_green,
   input  rgbyuv_pkg::pixel_type              req_blue,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  rgbyuv_pkg::pixel_type              rsp_luma,
   input  logic                               rsp_cb_valid,
   input  rgbyuv_pkg::pixel_type              rsp_cb_value,
   input  logic                               rsp_cr_valid,
   input  rgbyuv_pkg::pixel_type              rsp_cr_value,
   input  logic                               rsp_frame_end,
   input  logic                               csr_write_enable,
   input  logic [rgbyuv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rgbyuv_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                                 failures,
   output int                                 outstanding,
   output int                                 frame_ends
);

   rgbyuv_pkg::result_type             expected_pixels[$];
   logic [rgbyuv_pkg::CSR_DATA_W-1:0]  width_reg;
   logic [rgbyuv_pkg::CSR_DATA_W-1:0]  height_reg;
   logic [11:0]                        column_pos;
   logic [11:0]                        row_pos;
   int                                 fail_count;
   int                                 frame_end_count;

   assign failures   = fail_count;
   assign frame_ends = frame_end_count;

   function automatic int clamp_dimension(logic [rgbyuv_pkg::CSR_DATA_W-1:0] value);
      if (value < 2)
         return 2;
      if (value > MAX_DIM)
         return MAX_DIM;
      return int'(value);
   endfunction

   // floor((sum + bias) / 256) + offset, saturated to a pixel
   function automatic rgbyuv_pkg::pixel_type scale_component(int weighted, int offset);
      int level;
      level = ((weighted + rgbyuv_pkg::ROUND_BIAS) >>> rgbyuv_pkg::FRAC_BITS) + offset;
      if (level < 0)
         level = 0;
      if (level > rgbyuv_pkg::PIXEL_MAX)
         level = rgbyuv_pkg::PIXEL_MAX;
      return rgbyuv_pkg::pixel_type'(level);
   endfunction

   function automatic rgbyuv_pkg::result_type predict_conversion(
      rgbyuv_pkg::pixel_type r,
      rgbyuv_pkg::pixel_type g,
      rgbyuv_pkg::pixel_type b
   );
      rgbyuv_pkg::result_type res;
      int         ri;
      int         gi;
      int         bi;
      int         w;
      int         h;
      ri = int'(r);
      gi = int'(g);
      bi = int'(b);
      w  = clamp_dimension(width_reg);
      h  = clamp_dimension(height_reg);
      res.luma      = scale_component(rgbyuv_pkg::Y_R * ri + rgbyuv_pkg::Y_G * gi
                                      + rgbyuv_pkg::Y_B * bi, rgbyuv_pkg::Y_OFFSET);
      res.cb_value  = scale_component(rgbyuv_pkg::CB_R * ri + rgbyuv_pkg::CB_G * gi
                                      + rgbyuv_pkg::CB_B * bi, rgbyuv_pkg::C_OFFSET);
      res.cr_value  = scale_component(rgbyuv_pkg::CR_R * ri + rgbyuv_pkg::CR_G * gi
                                      + rgbyuv_pkg::CR_B * bi, rgbyuv_pkg::C_OFFSET);
      res.cb_valid  = !row_pos[0] && !column_pos[0];
      res.cr_valid  = !row_pos[0] && column_pos[0];
      res.frame_end = (int'(column_pos) >= w - 1) && (int'(row_pos) >= h - 1);
      return res;
   endfunction

   function automatic void step_position();
      if (int'(column_pos) >= clamp_dimension(width_reg) - 1) begin
         column_pos = '0;
         if (int'(row_pos) >= clamp_dimension(height_reg) - 1)
            row_pos = '0;
         else
            row_pos = row_pos + 1'b1;
      end else begin
         column_pos = column_pos + 1'b1;
      end
   endfunction

   task automatic compare_field(string name, int expected_value, int actual_value);
      if (expected_value != actual_value) begin
         $error("%s: expected %0d, got %0d", name, expected_value, actual_value);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rgbyuv_pkg::result_type want;
      if (reset) begin
         expected_pixels.delete();
         width_reg       = rgbyuv_pkg::FRAME_WIDTH_RESET;
         height_reg      = rgbyuv_pkg::FRAME_HEIGHT_RESET;
         column_pos      = '0;
         row_pos         = '0;
         fail_count      = 0;
         frame_end_count = 0;
         outstanding    <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_frame_end)
               frame_end_count++;
            if (expected_pixels.size() == 0) begin
               $error("result item with no pixel pending");
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               compare_field("luma", int'(want.luma), int'(rsp_luma));
               compare_field("cb_valid", int'(want.cb_valid), int'(rsp_cb_valid));
               compare_field("cb_value", int'(want.cb_value), int'(rsp_cb_value));
               compare_field("cr_valid", int'(want.cr_valid), int'(rsp_cr_valid));
               compare_field("cr_value", int'(want.cr_value), int'(rsp_cr_value));
               compare_field("frame_end", int'(want.frame_end), int'(rsp_frame_end));
            end
         end
         if (req_valid && req_ready) begin
            expected_pixels.push_back(predict_conversion(req_red, req_green, req_blue));
            step_position();
         end
         if (csr_write_enable) begin
            if (csr_index == rgbyuv_pkg::CSR_FRAME_WIDTH)
               width_reg = csr_write_data;
            else if (csr_index == rgbyuv_pkg::CSR_FRAME_HEIGHT)
               height_reg = csr_write_data;
         end
         outstanding <= expected_pixels.size();
      end
   end

endmodule

@@ verif/tb.sv @@
// Testbench top for the RGB to YUV 4:2:0 converter: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb;

   localparam int PIXEL_TARGET = 1700;
   localparam int CYCLE_LIMIT  = 600000;

   typedef logic [rgbyuv_pkg::CSR_DATA_W-1:0] csr_data_type;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   rgbyuv_pkg::pixel_type              req_red;
   rgbyuv_pkg::pixel_type              req_green;
   rgbyuv_pkg::pixel_type              req_blue;
   logic                               rsp_valid;
   logic                               rsp_ready;
   rgbyuv_pkg::pixel_type              rsp_luma;
   logic                               rsp_cb_valid;
   rgbyuv_pkg::pixel_type              rsp_cb_value;
   logic                               rsp_cr_valid;
   rgbyuv_pkg::pixel_type              rsp_cr_value;
   logic                               rsp_frame_end;
   logic                               csr_write_enable;
   logic [rgbyuv_pkg::CSR_INDEX_W-1:0] csr_index;
   csr_data_type                       csr_write_data;

   int   failures;
   int   outstanding;
   int   frame_ends;
   int   cycle_count;
   int   pixels_sent;
   int   settings_used;
   bit   steady;

   rgb_to_yuv420_converter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_luma         (rsp_luma),
      .rsp_cb_valid     (rsp_cb_valid),
      .rsp_cb_value     (rsp_cb_value),
      .rsp_cr_valid     (rsp_cr_valid),
      .rsp_cr_value     (rsp_cr_value),
      .rsp_frame_end    (rsp_frame_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   yuv420_result_checker result_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_luma         (rsp_luma),
      .rsp_cb_valid     (rsp_cb_valid),
      .rsp_cb_value     (rsp_cb_value),
      .rsp_cr_valid     (rsp_cr_valid),
      .rsp_cr_value     (rsp_cr_value),
      .rsp_frame_end    (rsp_frame_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .outstanding      (outstanding),
      .frame_ends       (frame_ends)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int pick_gap(int long_max);
      int roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, long_max);
   endfunction

   function automatic rgbyuv_pkg::pixel_type random_level();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return rgbyuv_pkg::pixel_type'($urandom_range(0, 255));
      endcase
   endfunction

   // result side: random stalls, none while steady
   initial begin
      int stall;
      int run;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (steady) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            stall = pick_gap(40);
            run   = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                : $urandom_range(1, 8);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            repeat (run) @(posedge clock);
         end
      end
   end

   task automatic send_pixel(rgbyuv_pkg::pixel_type r, rgbyuv_pkg::pixel_type g,
                             rgbyuv_pkg::pixel_type b);
      int gap;
      gap = pick_gap(30);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pixels_sent++;
   endtask

   // lower valid after the last item, then wait until every result is back
   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(rgbyuv_pkg::csr_index_type idx, csr_data_type value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_dimensions(csr_data_type w, csr_data_type h);
      write_register(rgbyuv_pkg::CSR_FRAME_WIDTH, w);
      write_register(rgbyuv_pkg::CSR_FRAME_HEIGHT, h);
      settings_used++;
   endtask

   initial begin
      int           phase_items;
      csr_data_type w;
      csr_data_type h;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_red          = '0;
      req_green        = '0;
      req_blue         = '0;
      csr_write_enable = 1'b0;
      csr_index        = rgbyuv_pkg::CSR_FRAME_WIDTH;
      csr_write_data   = '0;
      pixels_sent      = 0;
      settings_used    = 1;
      steady           = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // color corners at the reset frame size
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      settle_block();

      // shrink below minimum mid-line: column already past the end
      apply_dimensions(13'd0, 13'd1);
      repeat (5) send_pixel(random_level(), random_level(), random_level());
      settle_block();
      apply_dimensions(13'd3, 13'd2);
      repeat (3) send_pixel(random_level(), random_level(), random_level());
      settle_block();
      apply_dimensions(13'd8191, 13'd8191);
      repeat (3) send_pixel(random_level(), random_level(), random_level());
      settle_block();
      apply_dimensions(13'd4096, 13'd4097);
      send_pixel(8'd170, 8'd85, 8'd170);
      send_pixel(8'd85, 8'd170, 8'd85);
      settle_block();

      while (pixels_sent < PIXEL_TARGET) begin
         case ($urandom_range(0, 9))
            0: w = csr_data_type'($urandom_range(0, 1));
            1: w = csr_data_type'($urandom_range(4097, 8191));
            2: w = csr_data_type'($urandom_range(10, 70));
            default: w = csr_data_type'($urandom_range(2, 9));
         endcase
         case ($urandom_range(0, 9))
            0: h = csr_data_type'($urandom_range(0, 1));
            1: h = csr_data_type'($urandom_range(4097, 8191));
            default: h = csr_data_type'($urandom_range(2, 6));
         endcase
         case ($urandom_range(0, 2))
            0: apply_dimensions(w, h);
            1: begin
               write_register(rgbyuv_pkg::CSR_FRAME_WIDTH, w);
               settings_used++;
            end
            default: begin
               write_register(rgbyuv_pkg::CSR_FRAME_HEIGHT, h);
               settings_used++;
            end
         endcase
         steady      = ($urandom_range(0, 4) == 0);
         phase_items = $urandom_range(20, 120);
         repeat (phase_items)
            send_pixel(random_level(), random_level(), random_level());
         settle_block();
         steady = 1'b0;
      end

      $display("%0d pixels converted under %0d frame-size settings, %0d frame ends seen",
               pixels_sent, settings_used, frame_ends);
      if (failures == 0 && outstanding == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
